// File: rtl/les_pkg.sv
// les_pkg: shared types, codes and constants of the load state estimator.
// Used by every module in rtl; depends on nothing.

package les_pkg;

	localparam int STATE_COUNT_DEF    = 4;
	localparam int WINDOW_DEPTH_DEF   = 64;
	localparam int OFF_STATE_DEF      = 0;
	localparam int END_STATE_DEF      = 3;
	localparam int ON_STATE_FIRST_DEF = 1;
	localparam logic [31:0] INITIAL_MID_DEF = 32'h8000_0000;

	localparam int ST_W   = 3;
	localparam int VAL_W  = 15;
	localparam int LVL_W  = 18;
	localparam int DIVD_W = 33;
	localparam int DIVS_W = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_TRANS  = 2'd1;
	localparam logic [1:0] REQ_WSIZE  = 2'd2;

	localparam logic [1:0] CH_NONE = 2'd0;
	localparam logic [1:0] CH_ON   = 2'd1;
	localparam logic [1:0] CH_OFF  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MID_STEP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LP_WEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPD       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REJ_THR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REJ_CNT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_END   = 3'd5;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [11:0]        sample;
		logic [3:0]         table_index;
		logic signed [15:0] table_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0] change;
		logic       decided;
		logic [1:0] present_state;
	} out_item_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic dev;
		logic lp_start;
		logic lp_store;
		logic chk;
		logic adv_rd;
		logic adv_sub;
		logic adv_end;
		logic ins;
		logic bf_rd;
		logic bf_chk;
		logic avg_start;
		logic trans;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_sample;
		logic clr_last;
		logic div_done;
		logic decide;
		logic adv_more;
		logic bf_more;
		logic out_free;
	} status_t;

endpackage

// File: rtl/les_div.sv
// les_div: restoring divider, one quotient bit per cycle.
// Depends on les_pkg for operand widths.

module les_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [les_pkg::DIVD_W-1:0]    dividend,
	input  logic [les_pkg::DIVS_W-1:0]    divisor,
	output logic                          busy,
	output logic                          done,
	output logic [les_pkg::DIVD_W-1:0]    quotient
);

	localparam int DW  = les_pkg::DIVD_W;
	localparam int SW  = les_pkg::DIVS_W;
	localparam int CW  = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [SW:0]   rem_sh;
	logic          fits;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? SW'(rem_sh - {1'b0, dvs_q}) : rem_sh[SW-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/les_dp.sv
// les_dp: datapath of the load state estimator: filter, ring window memory,
// tables, configuration and result registers. Depends on les_pkg and les_div.

module les_dp #(
	parameter int          STATE_COUNT    = les_pkg::STATE_COUNT_DEF,
	parameter int          WINDOW_DEPTH   = les_pkg::WINDOW_DEPTH_DEF,
	parameter int          OFF_STATE      = les_pkg::OFF_STATE_DEF,
	parameter int          END_STATE      = les_pkg::END_STATE_DEF,
	parameter int          ON_STATE_FIRST = les_pkg::ON_STATE_FIRST_DEF,
	parameter logic [31:0] INITIAL_MID    = les_pkg::INITIAL_MID_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  les_pkg::cmd_t                      cmd,
	output les_pkg::status_t                   status,
	input  les_pkg::in_item_t                  in_data,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [les_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [les_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               out_stall,
	output logic                               out_valid,
	output les_pkg::out_item_t                 out_data
);

	localparam int IDX_W  = $clog2(WINDOW_DEPTH);
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = les_pkg::VAL_W + CNT_W;
	localparam int ST_W   = les_pkg::ST_W;
	localparam int SIDX_W = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
	localparam int TT_SIZE = STATE_COUNT * STATE_COUNT;
	localparam int TT_IW  = $clog2(TT_SIZE);
	localparam int VAL_W  = les_pkg::VAL_W;
	localparam int LVL_W  = les_pkg::LVL_W;
	localparam int DW     = les_pkg::DIVD_W;
	localparam int SW     = les_pkg::DIVS_W;

	// configuration
	logic [23:0] mid_step_q;
	logic [13:0] lp_weight_q;
	logic [15:0] spd_q;
	logic [14:0] rej_thr_q;
	logic [5:0]  rej_cnt_q;
	logic [15:0] max_end_q;

	// state
	logic [31:0]        midpoint_q;
	logic [LVL_W-1:0]   level_q;
	logic [15:0]        sample_count_q;
	logic [IDX_W-1:0]   next_q;
	logic [IDX_W-1:0]   oldest_q;
	logic [SUM_W-1:0]   sum_q;
	logic [15:0]        above_q;
	logic [ST_W-1:0]    state_q;
	logic [15:0]        end_timer_q;
	logic signed [15:0] tt_q [TT_SIZE];
	logic [CNT_W-1:0]   wst_q [STATE_COUNT];
	logic [15:0]        mem [WINDOW_DEPTH];

	// work registers
	les_pkg::in_item_t  item_q;
	logic [LVL_W-1:0]   dev_q;
	logic [31:0]        prod_q;
	logic [CNT_W-1:0]   size_q;
	logic [CNT_W-1:0]   used_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   bf_pos_q;
	logic [5:0]         bf_n_q;
	logic [15:0]        rdata_q;
	logic [IDX_W-1:0]   clr_q;
	logic               was_on_q;
	logic [1:0]         change_q;
	logic               decided_q;
	logic               out_valid_q;
	les_pkg::out_item_t out_q;

	// divider
	logic          div_start;
	logic [DW-1:0] div_dividend;
	logic [SW-1:0] div_divisor;
	logic          div_busy;
	logic          div_done;
	logic [DW-1:0] div_quot;

	function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] x);
		return (x == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : IDX_W'(x + 1'b1);
	endfunction

	function automatic logic [IDX_W-1:0] dec_idx(input logic [IDX_W-1:0] x);
		return (x == '0) ? IDX_W'(WINDOW_DEPTH - 1) : IDX_W'(x - 1'b1);
	endfunction

	// window occupancy
	logic [CNT_W:0]   used_wide;
	logic [CNT_W-1:0] used_now;
	always_comb begin
		if (oldest_q > next_q)
			used_wide = (CNT_W+1)'(next_q) + (CNT_W+1)'(WINDOW_DEPTH + 1)
				- (CNT_W+1)'(oldest_q);
		else
			used_wide = (CNT_W+1)'(next_q) - (CNT_W+1)'(oldest_q) + 1'b1;
	end
	assign used_now = used_wide[CNT_W-1:0];

	logic [CNT_W-1:0] cur_size;
	always_comb begin
		cur_size = CNT_W'(1);
		if (32'(state_q) < STATE_COUNT && wst_q[SIDX_W'(state_q)] != '0)
			cur_size = wst_q[SIDX_W'(state_q)];
	end

	// deviation step
	logic [31:0] scaled;
	logic [31:0] dev_full;
	logic [31:0] mid_next;
	always_comb begin
		scaled   = {item_q.sample, 20'b0};
		dev_full = '0;
		mid_next = midpoint_q;
		if (scaled > midpoint_q) begin
			dev_full = scaled - midpoint_q;
			mid_next = midpoint_q + {8'b0, mid_step_q};
		end else if (scaled < midpoint_q) begin
			dev_full = midpoint_q - scaled;
			mid_next = midpoint_q - {8'b0, mid_step_q};
		end
	end

	// insert step
	logic [VAL_W-1:0] ins_val;
	logic             ins_above;
	logic             ins_count;
	logic             ins_fill;
	logic [CNT_W:0]   older;
	logic [5:0]       fill_n;
	always_comb begin
		ins_val   = level_q[LVL_W-1:3];
		ins_above = ins_val > rej_thr_q;
		ins_count = ins_above && (above_q >= {10'b0, rej_cnt_q});
		ins_fill  = ins_count && (above_q == {10'b0, rej_cnt_q});
		older     = (CNT_W+1)'(used_now) - 1'b1;
		fill_n    = (16'(rej_cnt_q) <= 16'(older)) ? rej_cnt_q : 6'(older);
	end

	// transition step
	logic [VAL_W-1:0] avg;
	logic [ST_W-1:0]  st_pick;
	logic [ST_W-1:0]  st_new;
	logic [15:0]      tmr_inc;
	logic [15:0]      tmr_new;
	logic             found;
	logic [TT_IW-1:0] row_base;
	logic signed [16:0] tv;
	logic signed [16:0] av;
	logic             is_on;
	always_comb begin
		avg     = (div_quot > DW'(32767)) ? 15'h7fff : div_quot[VAL_W-1:0];
		av      = {2'b0, avg};
		st_pick = state_q;
		found   = 1'b0;
		row_base = TT_IW'(32'(SIDX_W'(state_q)) * STATE_COUNT);
		tv      = '0;
		if (32'(state_q) < STATE_COUNT) begin
			for (int i = 0; i < STATE_COUNT; i++) begin
				tv = 17'(tt_q[TT_IW'(row_base + TT_IW'(i))]);
				if (!found && ((tv < 0 && av < -tv) || (tv > 0 && av > tv))) begin
					st_pick = ST_W'(i);
					found   = 1'b1;
				end
			end
		end
		st_new  = st_pick;
		tmr_inc = end_timer_q + 1'b1;
		tmr_new = '0;
		if (st_pick == ST_W'(END_STATE)) begin
			tmr_new = tmr_inc;
			if (tmr_inc > max_end_q) begin
				tmr_new = '0;
				st_new  = ST_W'(OFF_STATE);
			end
		end
		is_on = st_new >= ST_W'(ON_STATE_FIRST);
	end

	// memory ports
	logic [IDX_W-1:0] raddr;
	logic [IDX_W-1:0] waddr;
	logic [15:0]      wdata;
	logic             we;
	always_comb begin
		raddr = cmd.adv_rd ? idx_q : dec_idx(bf_pos_q);
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		priority if (cmd.clr) begin
			we = 1'b1;
		end else if (cmd.ins) begin
			we    = 1'b1;
			waddr = next_q;
			wdata = {ins_count, ins_val};
		end else if (cmd.bf_chk && !rdata_q[15]) begin
			we    = 1'b1;
			waddr = bf_pos_q;
			wdata = {1'b1, rdata_q[VAL_W-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// divider operands
	assign div_start = cmd.lp_start || cmd.avg_start;
	always_comb begin
		if (cmd.lp_start) begin
			div_dividend = DW'(prod_q) + DW'(dev_q);
			div_divisor  = {1'b0, lp_weight_q} + SW'(1);
		end else begin
			div_dividend = DW'(sum_q);
			div_divisor  = SW'(used_now);
		end
	end

	les_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// control-state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_step_q     <= 24'd4096;
			lp_weight_q    <= 14'd15;
			spd_q          <= 16'd1000;
			rej_thr_q      <= '0;
			rej_cnt_q      <= '0;
			max_end_q      <= 16'hffff;
			midpoint_q     <= INITIAL_MID;
			level_q        <= '0;
			sample_count_q <= '0;
			next_q         <= '0;
			oldest_q       <= '0;
			sum_q          <= '0;
			above_q        <= '0;
			state_q        <= ST_W'(OFF_STATE);
			end_timer_q    <= '0;
			clr_q          <= '0;
			out_valid_q    <= 1'b0;
			for (int i = 0; i < TT_SIZE; i++)
				tt_q[i] <= '0;
			for (int i = 0; i < STATE_COUNT; i++)
				wst_q[i] <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					les_pkg::CFG_MID_STEP:  mid_step_q  <= cfg_data;
					les_pkg::CFG_LP_WEIGHT: lp_weight_q <= cfg_data[13:0];
					les_pkg::CFG_SPD:       spd_q       <= cfg_data[15:0];
					les_pkg::CFG_REJ_THR:   rej_thr_q   <= cfg_data[14:0];
					les_pkg::CFG_REJ_CNT:   rej_cnt_q   <= cfg_data[5:0];
					les_pkg::CFG_MAX_END:   max_end_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.clr)
				clr_q <= inc_idx(clr_q);
			if (cmd.accept) begin
				if (in_data.req_type == les_pkg::REQ_TRANS
						&& 32'(in_data.table_index) < TT_SIZE)
					tt_q[TT_IW'(in_data.table_index)] <= in_data.table_value;
				if (in_data.req_type == les_pkg::REQ_WSIZE
						&& 32'(in_data.table_index) < STATE_COUNT) begin
					if (in_data.table_value < 16'sd1)
						wst_q[SIDX_W'(in_data.table_index)] <= CNT_W'(1);
					else if (in_data.table_value > $signed(16'(WINDOW_DEPTH)))
						wst_q[SIDX_W'(in_data.table_index)] <= CNT_W'(WINDOW_DEPTH);
					else
						wst_q[SIDX_W'(in_data.table_index)] <=
							CNT_W'(in_data.table_value);
				end
			end
			if (cmd.dev) begin
				midpoint_q     <= mid_next;
				sample_count_q <= sample_count_q + 1'b1;
			end
			if (cmd.lp_store)
				level_q <= div_quot[LVL_W-1:0];
			if (cmd.chk && status.decide)
				sample_count_q <= '0;
			if (cmd.adv_sub && rdata_q[15])
				sum_q <= (sum_q >= SUM_W'(rdata_q[VAL_W-1:0]))
					? SUM_W'(sum_q - SUM_W'(rdata_q[VAL_W-1:0])) : '0;
			if (cmd.adv_end) begin
				oldest_q <= idx_q;
				next_q   <= inc_idx(next_q);
			end
			if (cmd.ins) begin
				if (ins_count) begin
					sum_q <= SUM_W'(sum_q + SUM_W'(ins_val));
					if (ins_fill)
						above_q <= 16'hffff;
				end else if (ins_above) begin
					above_q <= above_q + 1'b1;
				end else begin
					above_q <= '0;
				end
			end
			if (cmd.bf_chk && !rdata_q[15])
				sum_q <= SUM_W'(sum_q + SUM_W'(rdata_q[VAL_W-1:0]));
			if (cmd.trans) begin
				state_q     <= st_new;
				end_timer_q <= tmr_new;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q    <= in_data;
			decided_q <= 1'b0;
			change_q  <= les_pkg::CH_NONE;
		end
		if (cmd.dev) begin
			dev_q  <= dev_full[31:14];
			prod_q <= {14'b0, level_q} * {18'b0, lp_weight_q};
		end
		if (cmd.chk && status.decide) begin
			decided_q <= 1'b1;
			was_on_q  <= state_q >= ST_W'(ON_STATE_FIRST);
			size_q    <= cur_size;
			used_q    <= used_now;
			idx_q     <= oldest_q;
		end
		if (cmd.adv_sub) begin
			used_q <= used_q - 1'b1;
			idx_q  <= inc_idx(idx_q);
		end
		if (cmd.ins) begin
			bf_pos_q <= next_q;
			bf_n_q   <= ins_fill ? fill_n : '0;
		end
		if (cmd.bf_rd)
			bf_pos_q <= dec_idx(bf_pos_q);
		if (cmd.bf_chk)
			bf_n_q <= bf_n_q - 1'b1;
		if (cmd.trans && (was_on_q != is_on))
			change_q <= was_on_q ? les_pkg::CH_OFF : les_pkg::CH_ON;
		if (cmd.out_load) begin
			out_q.change        <= change_q;
			out_q.decided       <= decided_q;
			out_q.present_state <= state_q[1:0];
		end
	end

	assign status.is_sample = in_data.req_type == les_pkg::REQ_SAMPLE;
	assign status.clr_last  = clr_q == IDX_W'(WINDOW_DEPTH - 1);
	assign status.div_done  = div_done;
	assign status.decide    = sample_count_q >= spd_q;
	assign status.adv_more  = used_q >= size_q;
	assign status.bf_more   = bf_n_q != '0;
	assign status.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		used_now != '0 && 32'(used_now) <= WINDOW_DEPTH)
		else $error("window occupancy out of range");

	a_level_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lp_store |-> div_quot[DW-1:LVL_W] == '0)
		else $error("filtered level overflow");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> 16'(bf_n_q) < 16'(used_now))
		else $error("backfill walks past the window");

endmodule

// File: rtl/les_ctrl.sv
// les_ctrl: sequencer of the load state estimator.
// Depends on les_pkg for the command and status structs.

module les_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  les_pkg::status_t status,
	output les_pkg::cmd_t    cmd
);

	typedef enum logic [13:0] {
		S_CLEAR   = 14'h0001,
		S_IDLE    = 14'h0002,
		S_DEV     = 14'h0004,
		S_LPSTART = 14'h0008,
		S_LPDIV   = 14'h0010,
		S_CHK     = 14'h0020,
		S_ADV_RD  = 14'h0040,
		S_ADV_SUB = 14'h0080,
		S_INS     = 14'h0100,
		S_BF_RD   = 14'h0200,
		S_BF_CHK  = 14'h0400,
		S_AVGDIV  = 14'h0800,
		S_FINISH  = 14'h1000,
		S_SPARE   = 14'h2000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.is_sample ? S_DEV : S_FINISH;
				end
			end
			S_DEV: begin
				cmd.dev = 1'b1;
				state_d = S_LPSTART;
			end
			S_LPSTART: begin
				cmd.lp_start = 1'b1;
				state_d      = S_LPDIV;
			end
			S_LPDIV: begin
				if (status.div_done) begin
					cmd.lp_store = 1'b1;
					state_d      = S_CHK;
				end
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				state_d = status.decide ? S_ADV_RD : S_FINISH;
			end
			S_ADV_RD: begin
				if (status.adv_more) begin
					cmd.adv_rd = 1'b1;
					state_d    = S_ADV_SUB;
				end else begin
					cmd.adv_end = 1'b1;
					state_d     = S_INS;
				end
			end
			S_ADV_SUB: begin
				cmd.adv_sub = 1'b1;
				state_d     = S_ADV_RD;
			end
			S_INS: begin
				cmd.ins = 1'b1;
				state_d = S_BF_RD;
			end
			S_BF_RD: begin
				if (status.bf_more) begin
					cmd.bf_rd = 1'b1;
					state_d   = S_BF_CHK;
				end else begin
					cmd.avg_start = 1'b1;
					state_d       = S_AVGDIV;
				end
			end
			S_BF_CHK: begin
				cmd.bf_chk = 1'b1;
				state_d    = S_BF_RD;
			end
			S_AVGDIV: begin
				if (status.div_done) begin
					cmd.trans = 1'b1;
					state_d   = S_FINISH;
				end
			end
			S_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	assign in_stall = state_q != S_IDLE;

endmodule

// File: rtl/load_state_estimator.sv
// load_state_estimator: top level, sequencer plus datapath.
// Depends on les_pkg, les_ctrl, les_dp (and les_div below it).
//
// Usage: items enter on in_valid/in_stall as in_item_t beats; every item
// gives exactly one out_item_t beat on out_valid/out_stall. Registers are
// written on cfg_valid/cfg_ready (always ready); they must be written only
// while the block is idle, which the block itself does not enforce. A table
// write item goes from acceptance straight to its final step. A sample runs
// the level filter on the 33-step shared divider. A sample that closes a
// decision interval then retires window entries, inserts the new value,
// backfills entries and runs a second division for the average.
// One item is processed at a time; the next item is accepted as soon as
// the previous result sits in the output register, even while it is held.
// After reset the window memory is cleared, one entry per cycle, over all
// WINDOW_DEPTH entries; in_stall stays high during that pass.
// When out_stall holds a result, the next result waits in its final step.

module load_state_estimator #(
	parameter int          STATE_COUNT    = les_pkg::STATE_COUNT_DEF,
	parameter int          WINDOW_DEPTH   = les_pkg::WINDOW_DEPTH_DEF,
	parameter int          OFF_STATE      = les_pkg::OFF_STATE_DEF,
	parameter int          END_STATE      = les_pkg::END_STATE_DEF,
	parameter int          ON_STATE_FIRST = les_pkg::ON_STATE_FIRST_DEF,
	parameter logic [31:0] INITIAL_MID    = les_pkg::INITIAL_MID_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  les_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output les_pkg::out_item_t             out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [les_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [les_pkg::CFG_DATA_W-1:0] cfg_data
);

	les_pkg::cmd_t    cmd;
	les_pkg::status_t status;

	assign cfg_ready = 1'b1;

	les_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	les_dp #(
		.STATE_COUNT    (STATE_COUNT),
		.WINDOW_DEPTH   (WINDOW_DEPTH),
		.OFF_STATE      (OFF_STATE),
		.END_STATE      (END_STATE),
		.ON_STATE_FIRST (ON_STATE_FIRST),
		.INITIAL_MID    (INITIAL_MID)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
